// ===== design/stochastic_oscillator_macros.svh =====
// Assertion macros for the stochastic oscillator checker.
`ifndef STOCHASTIC_OSCILLATOR_MACROS_SVH
`define STOCHASTIC_OSCILLATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SO_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/stoch_pkg.sv =====
// ----------------------------------------------------------------------------
// stoch_pkg
// Shared widths, constants, hand-off item and state types of the
// stochastic oscillator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stoch_pkg;

    localparam int PRICE_W   = 24;
    localparam int PCT_W     = 15;
    localparam int PCT_SCALE = 25600;              // 100.0 with 8 fraction bits
    localparam int NUM_W     = PRICE_W + PCT_W;    // (price - low) * 25600
    localparam int QUO_W     = PCT_W;              // quotient never exceeds 25600
    localparam int STEP_W    = $clog2(QUO_W);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Item handed from the window scan to the arithmetic back end.
    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [PRICE_W-1:0] lo;
        logic [PRICE_W-1:0] hi;
        logic               full;
    } t_front_item;

    typedef enum logic [1:0] {
        F_IDLE,
        F_SCAN,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_DIV,
        B_AVG,
        B_RCP,
        B_FIN
    } t_back_state;

endpackage

`default_nettype wire

// ===== design/stoch_front.sv =====
// ----------------------------------------------------------------------------
// stoch_front
// Takes price items into a circular window memory and scans the newest
// K_PERIOD samples for their high and low, one memory read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stoch_front
    import stoch_pkg::*;
#(
    parameter int K_PERIOD = 14,
    parameter int D_PERIOD = 3
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [PRICE_W-1:0] i_price,
    output logic                    o_push,
    input  wire logic               i_full,
    output t_front_item             o_item
);

    localparam int WIN_DEPTH = K_PERIOD + D_PERIOD - 1;
    localparam int AW        = $clog2(K_PERIOD);
    localparam int AGW       = $clog2(K_PERIOD + 1);
    localparam int CW        = $clog2(WIN_DEPTH + 1);

    logic [PRICE_W-1:0] r_mem [K_PERIOD];

    t_front_state       r_state, n_state;
    logic [AW-1:0]      r_wp, n_wp;
    logic [AW-1:0]      r_raddr, n_raddr;
    logic [AGW-1:0]     r_age, n_age;
    logic [CW-1:0]      r_count, n_count;
    logic               r_pend, n_pend;
    logic               r_pend_live, n_pend_live;
    logic [PRICE_W-1:0] r_rdata;
    logic [PRICE_W-1:0] r_newest, n_newest;
    logic [PRICE_W-1:0] r_lo, n_lo;
    logic [PRICE_W-1:0] r_hi, n_hi;

    logic               mem_we;
    logic               rd_en;
    logic [PRICE_W-1:0] scan_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= F_IDLE;
            r_wp        <= '0;
            r_raddr     <= '0;
            r_age       <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_pend_live <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_wp        <= n_wp;
            r_raddr     <= n_raddr;
            r_age       <= n_age;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_pend_live <= n_pend_live;
        end
    end

    always_ff @(posedge i_clk) begin
        r_newest <= n_newest;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
    end

    // Window memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_wp] <= i_price;
        end
        if (rd_en) begin
            r_rdata <= r_mem[r_raddr];
        end
    end

    // Entries older than the sample count are read as zero; the memory itself is not reset.
    assign scan_val = r_pend_live ? r_rdata : '0;

    always_comb begin
        n_state     = r_state;
        n_wp        = r_wp;
        n_raddr     = r_raddr;
        n_age       = r_age;
        n_count     = r_count;
        n_pend      = r_pend;
        n_pend_live = r_pend_live;
        n_newest    = r_newest;
        n_lo        = r_lo;
        n_hi        = r_hi;
        mem_we      = 1'b0;
        rd_en       = 1'b0;
        o_ready     = 1'b0;
        o_push      = 1'b0;
        case (r_state)
            F_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    mem_we   = 1'b1;
                    n_newest = i_price;
                    n_lo     = i_price;
                    n_hi     = i_price;
                    n_count  = (r_count == CW'(WIN_DEPTH)) ? r_count : r_count + CW'(1);
                    n_age    = AGW'(1);
                    n_raddr  = (r_wp == AW'(0)) ? AW'(K_PERIOD - 1) : r_wp - AW'(1);
                    n_wp     = (r_wp == AW'(K_PERIOD - 1)) ? AW'(0) : r_wp + AW'(1);
                    n_pend   = 1'b0;
                    n_state  = F_SCAN;
                end
            end
            F_SCAN: begin
                if (r_age != AGW'(K_PERIOD)) begin
                    rd_en       = 1'b1;
                    n_pend      = 1'b1;
                    n_pend_live = CW'(r_age) < r_count;
                    n_age       = r_age + AGW'(1);
                    n_raddr     = (r_raddr == AW'(0)) ? AW'(K_PERIOD - 1)
                                                      : r_raddr - AW'(1);
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (scan_val < r_lo) begin
                        n_lo = scan_val;
                    end
                    if (scan_val > r_hi) begin
                        n_hi = scan_val;
                    end
                end
                if (r_age == AGW'(K_PERIOD) && !r_pend) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_comb begin
        o_item.price = r_newest;
        o_item.lo    = r_lo;
        o_item.hi    = r_hi;
        o_item.full  = (r_count == CW'(WIN_DEPTH));
    end

endmodule

`default_nettype wire

// ===== design/stoch_fifo.sv =====
// ----------------------------------------------------------------------------
// stoch_fifo
// Short queue between the window scan and the arithmetic back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stoch_fifo
    import stoch_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire t_front_item  i_item,
    output logic              o_full,
    input  wire logic         i_pop,
    output logic              o_empty,
    output t_front_item       o_item
);

    t_front_item          r_buf [FIFO_DEPTH];
    logic [FIFO_PW-1:0]   r_wr, n_wr;
    logic [FIFO_PW-1:0]   r_rd, n_rd;
    logic [FIFO_CW-1:0]   r_cnt, n_cnt;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_cnt == FIFO_CW'(FIFO_DEPTH));
    assign o_empty = (r_cnt == FIFO_CW'(0));
    assign o_item  = r_buf[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = do_push ? r_wr + FIFO_PW'(1) : r_wr;
        n_rd  = do_pop  ? r_rd + FIFO_PW'(1) : r_rd;
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + FIFO_CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - FIFO_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/stoch_back.sv =====
// ----------------------------------------------------------------------------
// stoch_back
// Forms %K with a restoring divider, keeps the %K history, averages it
// into %D by reciprocal multiply, and holds the result in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stoch_back
    import stoch_pkg::*;
#(
    parameter int D_PERIOD = 3
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_empty,
    input  wire t_front_item      i_item,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [PCT_W-1:0]      o_k_percent,
    output logic [PCT_W-1:0]      o_d_percent,
    output logic                  o_flat_window,
    output logic                  o_valid_res
);

    localparam int HD     = (D_PERIOD > 1) ? D_PERIOD - 1 : 1;
    localparam int DSUM_W = PCT_W + $clog2(D_PERIOD);
    localparam int RCP_SH = DSUM_W;
    localparam int RW     = RCP_SH + 1;
    localparam int RECIP  = (1 << RCP_SH) / D_PERIOD;

    t_back_state          r_state, n_state;
    t_front_item          r_item;
    logic [PRICE_W-1:0]   r_rem, n_rem;
    logic [QUO_W-1:0]     r_quo, n_quo;
    logic [PRICE_W-1:0]   r_den, n_den;
    logic                 r_flat, n_flat;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [DSUM_W-1:0]    r_dsum, n_dsum;
    logic [DSUM_W-1:0]    r_q0, n_q0;
    logic [PCT_W-1:0]     r_hist [HD];

    logic                 r_out_valid, n_out_valid;
    logic [PCT_W-1:0]     r_out_k, n_out_k;
    logic [PCT_W-1:0]     r_out_d, n_out_d;
    logic                 r_out_flat, n_out_flat;
    logic                 r_out_full, n_out_full;

    logic                 hist_we;
    logic [PRICE_W-1:0]   diff;
    logic [NUM_W-1:0]     num;
    logic [PRICE_W:0]     trial;
    logic [DSUM_W-1:0]    dsum_c;
    logic [DSUM_W+RW-1:0] rcp_prod;
    logic [DSUM_W-1:0]    qd;
    logic [DSUM_W-1:0]    rem_d;
    logic [DSUM_W-1:0]    dq;

    assign diff     = r_item.price - r_item.lo;
    assign num      = NUM_W'(diff) * NUM_W'(PCT_SCALE);
    assign trial    = {r_rem, r_quo[QUO_W-1]};
    assign rcp_prod = r_dsum * RW'(RECIP);
    assign qd       = r_q0 * DSUM_W'(D_PERIOD);
    assign rem_d    = r_dsum - qd;
    // The reciprocal quotient is low by at most one.
    assign dq       = (rem_d >= DSUM_W'(D_PERIOD)) ? r_q0 + DSUM_W'(1) : r_q0;

    always_comb begin
        dsum_c = DSUM_W'(r_quo);
        for (int i = 0; i < D_PERIOD - 1; i++) begin
            dsum_c = dsum_c + DSUM_W'(r_hist[i]);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_den       = r_den;
        n_flat      = r_flat;
        n_step      = r_step;
        n_dsum      = r_dsum;
        n_q0        = r_q0;
        n_out_valid = r_out_valid && !i_ready;
        n_out_k     = r_out_k;
        n_out_d     = r_out_d;
        n_out_flat  = r_out_flat;
        n_out_full  = r_out_full;
        hist_we     = 1'b0;
        o_pop       = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = B_MUL;
                end
            end
            B_MUL: begin
                n_den  = r_item.hi - r_item.lo;
                n_flat = (r_item.hi == r_item.lo);
                n_step = '0;
                if (r_item.hi == r_item.lo) begin
                    n_quo   = '0;
                    n_state = B_AVG;
                end else begin
                    // Quotient fits QUO_W bits, so the top part is below the divisor.
                    n_rem   = num[NUM_W-1:QUO_W];
                    n_quo   = num[QUO_W-1:0];
                    n_state = B_DIV;
                end
            end
            B_DIV: begin
                if (trial >= {1'b0, r_den}) begin
                    n_rem = PRICE_W'(trial - {1'b0, r_den});
                    n_quo = {r_quo[QUO_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[PRICE_W-1:0];
                    n_quo = {r_quo[QUO_W-2:0], 1'b0};
                end
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(QUO_W - 1)) begin
                    n_state = B_AVG;
                end
            end
            B_AVG: begin
                n_dsum  = dsum_c;
                hist_we = 1'b1;
                n_state = B_RCP;
            end
            B_RCP: begin
                n_q0    = rcp_prod[RCP_SH +: DSUM_W];
                n_state = B_FIN;
            end
            B_FIN: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_k     = r_quo;
                    n_out_d     = dq[PCT_W-1:0];
                    n_out_flat  = r_flat;
                    n_out_full  = r_item.full;
                    n_state     = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_den      <= n_den;
        r_flat     <= n_flat;
        r_dsum     <= n_dsum;
        r_q0       <= n_q0;
        r_out_k    <= n_out_k;
        r_out_d    <= n_out_d;
        r_out_flat <= n_out_flat;
        r_out_full <= n_out_full;
    end

    // %K history, newest in entry 0.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HD; i++) begin
                r_hist[i] <= '0;
            end
        end else if (hist_we) begin
            for (int i = HD - 1; i > 0; i--) begin
                r_hist[i] <= r_hist[i-1];
            end
            if (D_PERIOD > 1) begin
                r_hist[0] <= r_quo;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_k_percent   = r_out_k;
    assign o_d_percent   = r_out_d;
    assign o_flat_window = r_out_flat;
    assign o_valid_res   = r_out_full;

endmodule

`default_nettype wire

// ===== design/stochastic_oscillator.sv =====
// ----------------------------------------------------------------------------
// stochastic_oscillator
// %K over K_PERIOD price samples and %D over D_PERIOD %K values.
// ----------------------------------------------------------------------------
// Each accepted price item yields exactly one result item: %K and %D in
// unsigned fixed point with 8 fraction bits (25600 = 100%), truncated, a
// flat-window flag (high equals low, %K forced to 0) and valid_res, which
// rises once K_PERIOD + D_PERIOD - 1 samples have arrived. Before that the
// window counts as zeros. The front end keeps the window in a circular
// memory and is bounded by one registered read per older window entry. The
// back end is bounded by its 15-step restoring divider, which a flat window
// skips. A two-entry queue sits between the stages and an output register
// follows the back end; the front end takes a new item only after pushing
// the last one into the queue. No clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stochastic_oscillator
    import stoch_pkg::*;
#(
    parameter int K_PERIOD = 14,
    parameter int D_PERIOD = 3
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [PRICE_W-1:0] i_price,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [PCT_W-1:0]        o_k_percent,
    output logic [PCT_W-1:0]        o_d_percent,
    output logic                    o_flat_window,
    output logic                    o_valid_res
);

    t_front_item front_item;
    t_front_item queue_item;
    logic        push;
    logic        full;
    logic        pop;
    logic        empty;

    stoch_front #(
        .K_PERIOD (K_PERIOD),
        .D_PERIOD (D_PERIOD)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_price (i_price),
        .o_push  (push),
        .i_full  (full),
        .o_item  (front_item)
    );

    stoch_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_item  (queue_item)
    );

    stoch_back #(
        .D_PERIOD (D_PERIOD)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_item        (queue_item),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_k_percent   (o_k_percent),
        .o_d_percent   (o_d_percent),
        .o_flat_window (o_flat_window),
        .o_valid_res   (o_valid_res)
    );

endmodule

`default_nettype wire

// ===== design/stoch_checker.sv =====
// ----------------------------------------------------------------------------
// stoch_checker
// Port-level checks of the stochastic oscillator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "stochastic_oscillator_macros.svh"

module stoch_checker
    import stoch_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_valid,
    input wire logic               o_ready,
    input wire logic [PRICE_W-1:0] i_price,
    input wire logic               o_valid,
    input wire logic               i_ready,
    input wire logic [PCT_W-1:0]   o_k_percent,
    input wire logic [PCT_W-1:0]   o_d_percent,
    input wire logic               o_flat_window,
    input wire logic               o_valid_res
);

    `SO_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid, "result item dropped while stalled")
    `SO_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_k_percent) && $stable(o_d_percent) && $stable(o_valid_res), "stalled result item changed")
    `SO_ASSERT_NOW(a_k_range, i_clk, i_rst_n, o_valid, o_k_percent <= PCT_W'(PCT_SCALE), "k_percent above full scale")
    `SO_ASSERT_NOW(a_d_range, i_clk, i_rst_n, o_valid, o_d_percent <= PCT_W'(PCT_SCALE), "d_percent above full scale")
    `SO_ASSERT_NOW(a_flat_zero, i_clk, i_rst_n, o_valid && o_flat_window, o_k_percent == '0, "flat window with nonzero k_percent")

endmodule

bind stochastic_oscillator stoch_checker u_stoch_checker (.*);

`default_nettype wire
